/* rtl/timestamp_ordered_sensor_merge_core_defines.svh */
// Assertion macros shared by the merge core.
`ifndef TIMESTAMP_ORDERED_SENSOR_MERGE_CORE_DEFINES_SVH
`define TIMESTAMP_ORDERED_SENSOR_MERGE_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tsm_pkg.sv */
package tsm_pkg;

	localparam int ADDR_BITS   = 3;
	localparam int MASK_BITS   = 8;
	localparam int STAMP_BITS  = 64;
	localparam int WORD_BITS   = 64;
	localparam int COUNT_BITS  = 10;

	localparam logic REG_SENSOR_ENABLE = 1'b0;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef logic [1:0] cause_t;
	localparam cause_t CAUSE_NONE        = 2'd0;
	localparam cause_t CAUSE_NOT_ENABLED = 2'd1;
	localparam cause_t CAUSE_QUEUE_FULL  = 2'd2;
	localparam cause_t CAUSE_EMPTY       = 2'd3;

endpackage

/* rtl/timestamp_ordered_sensor_merge_core.sv */
// Push: the item passes through the DONE state into the output register; pop: through SCAN,
// DRAIN, COMMIT and DONE, the scan reading one sensor head per cycle from the stamp/payload memory.
// One item is in work at a time: a new item is taken only once the last one is back in idle,
// which is held back while a finished result still waits for the output register.
// Reset (arst_n low, asynchronous) clears the enable mask, head pointers, occupancy and
// control; the entry memories are not cleared and need no clearing pass.
`include "timestamp_ordered_sensor_merge_core_defines.svh"

module timestamp_ordered_sensor_merge_core
	import tsm_pkg::*;
#(
	parameter int NUM_SENSORS  = 8,
	parameter int QUEUE_DEPTH  = 64,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [2:0]                   sensor_index,
	input  logic signed [STAMP_BITS-1:0] stamp_in,
	input  logic [WORD_BITS-1:0]         payload_in,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         ok,
	output logic [1:0]                   fail_cause,
	output logic [2:0]                   sensor_out,
	output logic signed [STAMP_BITS-1:0] stamp_out,
	output logic [WORD_BITS-1:0]         payload_out,
	output logic [COUNT_BITS-1:0]        total_count,
	output logic                         all_empty
);

	// Widths that follow from the geometry.
	localparam int SIW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int OW  = $clog2(QUEUE_DEPTH + 1);
	localparam int AW  = $clog2(NUM_SENSORS * QUEUE_DEPTH);
	localparam int TW  = $clog2(NUM_SENSORS * QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_SENSORS * QUEUE_DEPTH;
	localparam logic [SIW-1:0] LAST_SENSOR = SIW'(NUM_SENSORS - 1);

	// Sequencer codes.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_COMMIT = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	// Entry memories: one queue of QUEUE_DEPTH entries per sensor, back to back.
	logic [STAMP_BITS-1:0]   stamp_mem   [MEM_DEPTH];
	logic [PAYLOAD_BITS-1:0] payload_mem [MEM_DEPTH];

	logic [7:0]              mask_q;
	logic [2:0]              state_q;
	logic [PW-1:0]           head_q [NUM_SENSORS];
	logic [OW-1:0]           occ_q  [NUM_SENSORS];
	logic [TW-1:0]           total_q;
	logic [SIW-1:0]          scan_q;

	// Head read pipeline: stage 1 is the cycle the memory data comes back.
	logic                    rd_vld_s1;
	logic [SIW-1:0]          rd_idx_s1;
	logic [STAMP_BITS-1:0]   stamp_rd_q;
	logic [PAYLOAD_BITS-1:0] payload_rd_q;

	// Best head found so far in the scan.
	logic                    found_q;
	logic [SIW-1:0]          best_idx_q;
	logic [STAMP_BITS-1:0]   best_stamp_q;
	logic [PAYLOAD_BITS-1:0] best_payload_q;

	// Result waiting for the output register.
	logic                    res_ok_q;
	cause_t                  res_cause_q;
	logic [2:0]              res_sensor_q;
	logic [STAMP_BITS-1:0]   res_stamp_q;
	logic [WORD_BITS-1:0]    res_payload_q;

	// Output register.
	logic                    out_valid_q;
	logic                    out_ok_q;
	cause_t                  out_cause_q;
	logic [2:0]              out_sensor_q;
	logic [STAMP_BITS-1:0]   out_stamp_q;
	logic [WORD_BITS-1:0]    out_payload_q;
	logic [COUNT_BITS-1:0]   out_total_q;
	logic                    out_empty_q;

	logic                    cfg_write;
	logic                    in_accept;
	logic                    out_free;
	logic [SIW-1:0]          push_idx;
	logic [SIW-1:0]          acc_idx;
	logic [PW-1:0]           acc_head;
	logic [OW-1:0]           acc_occ;
	logic [PW-1:0]           acc_head_next;
	logic [OW:0]             tail_sum;
	logic [PW-1:0]           tail_slot;
	logic                    push_in_range;
	logic                    push_enabled;
	logic                    push_full;
	logic                    push_write;
	logic [AW-1:0]           mem_addr;
	logic                    take_best;

	function automatic logic [AW-1:0] entry_addr(input logic [SIW-1:0] idx,
		input logic [PW-1:0] slot);
		logic [AW:0] full_addr;
		full_addr = (AW+1)'(idx) * (AW+1)'(QUEUE_DEPTH) + (AW+1)'(slot);
		return full_addr[AW-1:0];
	endfunction

	// Configuration port: zero wait states, one register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[ADDR_BITS-1] == REG_SENSOR_ENABLE) ? 32'(mask_q) : 32'd0;

	// Handshakes: take an item only when no other item is in work.
	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// One shared index into the per-sensor pointer and occupancy flops.
	assign push_idx = SIW'(sensor_index);
	always_comb begin
		case (state_q)
			ST_SCAN:   acc_idx = scan_q;
			ST_COMMIT: acc_idx = best_idx_q;
			default:   acc_idx = push_idx;
		endcase
	end
	assign acc_head      = head_q[acc_idx];
	assign acc_occ       = occ_q[acc_idx];
	assign acc_head_next = (acc_head == PW'(QUEUE_DEPTH - 1)) ? '0 : acc_head + 1'b1;

	// Tail slot = head + occupancy, wrapped once around the queue.
	assign tail_sum  = (OW+1)'(acc_head) + (OW+1)'(acc_occ);
	assign tail_slot = (tail_sum >= (OW+1)'(QUEUE_DEPTH))
		? PW'(tail_sum - (OW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);

	// Push checks: a disabled or missing slot reports not enabled ahead of full.
	assign push_in_range = {29'd0, sensor_index} < 32'(NUM_SENSORS);
	assign push_enabled  = push_in_range && mask_q[sensor_index];
	assign push_full     = (acc_occ == OW'(QUEUE_DEPTH));
	assign push_write    = in_accept && (cmd == CMD_PUSH) && push_enabled && !push_full;

	assign mem_addr = (state_q == ST_SCAN) ? entry_addr(scan_q, acc_head)
		: entry_addr(push_idx, tail_slot);

	// Strict less-than keeps the lowest sensor on equal stamps.
	assign take_best = rd_vld_s1 && (!found_q || ($signed(stamp_rd_q) < $signed(best_stamp_q)));

	// Entry memories: write on push, registered read during the scan.
	always_ff @(posedge clk) begin
		if (push_write) begin
			stamp_mem[mem_addr]   <= stamp_in;
			payload_mem[mem_addr] <= payload_in[PAYLOAD_BITS-1:0];
		end
		stamp_rd_q   <= stamp_mem[mem_addr];
		payload_rd_q <= payload_mem[mem_addr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			state_q     <= ST_IDLE;
			total_q     <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				head_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			if (cfg_write && (paddr[ADDR_BITS-1] == REG_SENSOR_ENABLE)) begin
				mask_q <= pwdata[MASK_BITS-1:0];
			end
			// Load the output register from a finished item, else drop it once taken.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_best) begin
				found_q <= 1'b1;
			end
			// Issue one head read a cycle; skip empty queues at compare time.
			rd_vld_s1 <= (state_q == ST_SCAN) && (acc_occ != '0);
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (cmd == CMD_PUSH) begin
							// Append at the tail and count the new entry.
							if (push_write) begin
								occ_q[acc_idx] <= acc_occ + 1'b1;
								total_q        <= total_q + 1'b1;
							end
							state_q <= ST_DONE;
						end else begin
							found_q <= 1'b0;
							scan_q  <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q == LAST_SENSOR) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					// Drop the winning head from its queue.
					if (found_q) begin
						head_q[acc_idx] <= acc_head_next;
						occ_q[acc_idx]  <= acc_occ - 1'b1;
						total_q         <= total_q - 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: scan index pipeline, best head, result staging, output.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (take_best) begin
			best_idx_q     <= rd_idx_s1;
			best_stamp_q   <= stamp_rd_q;
			best_payload_q <= payload_rd_q;
		end
		if (state_q == ST_IDLE && in_accept && cmd == CMD_PUSH) begin
			res_ok_q      <= push_write;
			res_cause_q   <= !push_enabled ? CAUSE_NOT_ENABLED
				: (push_full ? CAUSE_QUEUE_FULL : CAUSE_NONE);
			res_sensor_q  <= '0;
			res_stamp_q   <= '0;
			res_payload_q <= '0;
		end
		if (state_q == ST_COMMIT) begin
			res_ok_q      <= found_q;
			res_cause_q   <= found_q ? CAUSE_NONE : CAUSE_EMPTY;
			res_sensor_q  <= found_q ? 3'(best_idx_q) : 3'd0;
			res_stamp_q   <= found_q ? best_stamp_q : '0;
			res_payload_q <= found_q ? WORD_BITS'(best_payload_q) : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_ok_q      <= res_ok_q;
			out_cause_q   <= res_cause_q;
			out_sensor_q  <= res_sensor_q;
			out_stamp_q   <= res_stamp_q;
			out_payload_q <= res_payload_q;
			out_total_q   <= COUNT_BITS'(total_q);
			out_empty_q   <= (total_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign fail_cause  = out_cause_q;
	assign sensor_out  = out_sensor_q;
	assign stamp_out   = $signed(out_stamp_q);
	assign payload_out = out_payload_q;
	assign total_count = out_total_q;
	assign all_empty   = out_empty_q;

	`TSM_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != ST_IDLE, "stayed idle")
	`TSM_ASSERT_NOW(a_total_bound, 1'b1, total_q <= TW'(MEM_DEPTH), "total above capacity")
	`TSM_ASSERT_NOW(a_read_in_scan, rd_vld_s1, state_q == ST_SCAN || state_q == ST_DRAIN, "stray")
	`TSM_ASSERT_NOW(a_ok_no_cause, out_valid_q && out_ok_q, out_cause_q == CAUSE_NONE, "ok+cause")
	`TSM_ASSERT_NEXT(a_commit_to_done, state_q == ST_COMMIT, state_q == ST_DONE, "commit stuck")

endmodule

/* verif/tb_timestamp_ordered_sensor_merge_core.sv */
module tb_timestamp_ordered_sensor_merge_core
	import tsm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SENSORS  = 8;
	localparam int QUEUE_DEPTH  = 64;
	localparam int PAYLOAD_BITS = 64;

	localparam logic [ADDR_BITS-1:0] ENABLE_ADDR = ADDR_BITS'(4 * REG_SENSOR_ENABLE);
	localparam logic signed [STAMP_BITS-1:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [STAMP_BITS-1:0] STAMP_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [WORD_BITS-1:0] PAYLOAD_KEEP = {WORD_BITS{1'b1}} >> (64 - PAYLOAD_BITS);

	// One queued sensor entry and one result as the block reports it.
	typedef struct {
		logic signed [STAMP_BITS-1:0] stamp;
		logic [WORD_BITS-1:0]         payload;
	} entry_t;

	typedef struct {
		logic                         ok;
		cause_t                       cause;
		logic [2:0]                   sensor;
		logic signed [STAMP_BITS-1:0] stamp;
		logic [WORD_BITS-1:0]         payload;
		logic [COUNT_BITS-1:0]        total;
		logic                         all_empty;
	} result_t;

	// Shadow of the per-sensor queues plus the list of results still owed.
	class merge_scoreboard;
		entry_t          lanes[NUM_SENSORS][$];
		logic [7:0]      enable_mask;
		result_t         expected[$];
		int              mismatches;
		int              stored;
		int              merged;
		int              refused[4];
		int              peak;

		function new();
			enable_mask = '0;
			mismatches  = 0;
			stored      = 0;
			merged      = 0;
			peak        = 0;
			foreach (refused[i]) refused[i] = 0;
		endfunction

		function void set_mask(logic [7:0] m);
			enable_mask = m;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void mismatch(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] MISMATCH %s", $realtime, what);
		endfunction

		function string fmt(result_t r);
			return $sformatf("ok=%0b cause=%0d sensor=%0d stamp=%0d payload=%h total=%0d empty=%0b",
				r.ok, r.cause, r.sensor, r.stamp, r.payload, r.total, r.all_empty);
		endfunction

		// Apply one accepted item to the shadow queues and queue its result.
		function void note_item(logic c, logic [2:0] s, logic signed [STAMP_BITS-1:0] st,
				logic [WORD_BITS-1:0] pl);
			result_t r;
			entry_t  e;
			int      best;
			int      held;
			r = '{1'b0, CAUSE_NONE, 3'd0, '0, '0, '0, 1'b0};
			if (c == CMD_PUSH) begin
				if (int'(s) >= NUM_SENSORS || !enable_mask[s]) begin
					r.cause = CAUSE_NOT_ENABLED;
				end else if (lanes[s].size() >= QUEUE_DEPTH) begin
					r.cause = CAUSE_QUEUE_FULL;
				end else begin
					e.stamp   = st;
					e.payload = pl & PAYLOAD_KEEP;
					lanes[s].insert(lanes[s].size(), e);
					r.ok = 1'b1;
					stored++;
				end
			end else begin
				// Strict less-than keeps the lowest sensor on equal stamps.
				best = -1;
				for (int i = 0; i < NUM_SENSORS; i++)
					if (lanes[i].size() != 0 &&
					    (best < 0 || lanes[i][0].stamp < lanes[best][0].stamp))
						best = i;
				if (best < 0) begin
					r.cause = CAUSE_EMPTY;
				end else begin
					e         = lanes[best][0];
					lanes[best].delete(0);
					r.ok      = 1'b1;
					r.sensor  = 3'(best);
					r.stamp   = e.stamp;
					r.payload = e.payload;
					merged++;
				end
			end
			refused[r.cause] += (r.ok ? 0 : 1);
			held = 0;
			for (int i = 0; i < NUM_SENSORS; i++)
				held += lanes[i].size();
			if (held > peak)
				peak = held;
			r.total     = COUNT_BITS'(held);
			r.all_empty = (held == 0);
			expected.insert(expected.size(), r);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (expected.size() == 0) begin
				mismatch({"result with nothing owed: ", fmt(got)});
				return;
			end
			e = expected[0];
			expected.delete(0);
			if (got.ok !== e.ok || got.cause !== e.cause || got.sensor !== e.sensor ||
			    got.stamp !== e.stamp || got.payload !== e.payload ||
			    got.total !== e.total || got.all_empty !== e.all_empty)
				mismatch({"\n  expected ", fmt(e), "\n  actual   ", fmt(got)});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [ADDR_BITS-1:0]         paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         cmd = CMD_PUSH;
	logic [2:0]                   sensor_index = '0;
	logic signed [STAMP_BITS-1:0] stamp_in = '0;
	logic [WORD_BITS-1:0]         payload_in = '0;

	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         ok;
	logic [1:0]                   fail_cause;
	logic [2:0]                   sensor_out;
	logic signed [STAMP_BITS-1:0] stamp_out;
	logic [WORD_BITS-1:0]         payload_out;
	logic [COUNT_BITS-1:0]        total_count;
	logic                         all_empty;

	merge_scoreboard sb = new();

	// Chance in percent that an idle burst starts; zero gives back-to-back traffic.
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;

	timestamp_ordered_sensor_merge_core #(
		.NUM_SENSORS (NUM_SENSORS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.sensor_index(sensor_index),
		.stamp_in    (stamp_in),
		.payload_in  (payload_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.fail_cause  (fail_cause),
		.sensor_out  (sensor_out),
		.stamp_out   (stamp_out),
		.payload_out (payload_out),
		.total_count (total_count),
		.all_empty   (all_empty)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Result side: check each accepted result, then pick ready for the next cycle.
	initial begin
		int      stall;
		result_t got;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.ok        = ok;
				got.cause     = fail_cause;
				got.sensor    = sensor_out;
				got.stamp     = stamp_out;
				got.payload   = payload_out;
				got.total     = total_count;
				got.all_empty = all_empty;
				sb.check_result(got);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (receiver_idle_pct != 0 && $urandom_range(1, 100) <= receiver_idle_pct) begin
				out_ready <= 1'b0;
				stall = $urandom_range(1, 7) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Present one item, hold it until accepted, then maybe leave a gap.
	// Entered and left at a rising edge.
	task automatic send(input logic c, input logic [2:0] s,
			input logic signed [STAMP_BITS-1:0] st, input logic [WORD_BITS-1:0] pl);
		in_valid     <= 1'b1;
		cmd          <= c;
		sensor_index <= s;
		stamp_in     <= st;
		payload_in   <= pl;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(c, s, st, pl);
		if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every owed result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	// Write the enable mask over the config port, then read it back.
	task automatic write_enable_mask(input logic [7:0] m);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ENABLE_ADDR;
		pwdata  <= {24'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_mask(m);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata[MASK_BITS-1:0] !== m)
			sb.mismatch($sformatf("enable mask read back %h, wrote %h",
				prdata[MASK_BITS-1:0], m));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mix extremes, tight clusters around zero (ties) and wide random stamps.
	function automatic logic signed [STAMP_BITS-1:0] random_stamp();
		logic signed [STAMP_BITS-1:0] v;
		case ($urandom_range(0, 7))
			0: v = STAMP_MAX;
			1: v = STAMP_MIN;
			2, 3: begin
				v = STAMP_BITS'(signed'($urandom_range(0, 8)) - 4);
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [WORD_BITS-1:0] random_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly aim pushes at enabled sensors so the queues actually fill.
	function automatic logic [2:0] pick_sensor(input logic [7:0] m);
		logic [2:0] s;
		s = 3'($urandom_range(0, NUM_SENSORS - 1));
		if (m != '0 && $urandom_range(0, 99) < 85)
			while (!m[s])
				s = 3'($urandom_range(0, NUM_SENSORS - 1));
		return s;
	endfunction

	// One random phase: set the mask while idle, then stream items.
	task automatic run_phase(input logic [7:0] m, input int push_pct, input int n_items,
			input bit round_robin, input int idle_pct);
		logic       c;
		logic [2:0] s;
		drain();
		write_enable_mask(m);
		sender_idle_pct   = idle_pct;
		receiver_idle_pct = idle_pct;
		for (int i = 0; i < n_items; i++) begin
			c = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
			s = round_robin ? 3'(i % NUM_SENSORS) : pick_sensor(m);
			// Now and then let the pipeline run completely dry mid-phase.
			if (idle_pct != 0 && $urandom_range(0, 63) == 0)
				drain();
			send(c, s, random_stamp(), random_payload());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop and disabled push straight out of reset.
		sender_idle_pct   = 10;
		receiver_idle_pct = 10;
		send(CMD_POP, 3'd0, '0, '0);
		send(CMD_PUSH, 3'd4, 64'sd7, '1);
		drain();
		write_enable_mask(8'hFF);

		// A head holding the largest stamp must still come out.
		send(CMD_PUSH, 3'd0, STAMP_MAX, '1);
		send(CMD_POP, 3'd0, '0, '0);

		// Extremes and a three-way tie: expect min, -1, then sensors 1, 3, 6, then max.
		send(CMD_PUSH, 3'd7, STAMP_MIN, '0);
		send(CMD_PUSH, 3'd5, STAMP_MAX, 64'h8000_0000_0000_0001);
		send(CMD_PUSH, 3'd3, 64'sd5, 64'h0123_4567_89AB_CDEF);
		send(CMD_PUSH, 3'd1, 64'sd5, 64'hFEDC_BA98_7654_3210);
		send(CMD_PUSH, 3'd6, 64'sd5, 64'h5555_5555_5555_5555);
		send(CMD_PUSH, 3'd2, -64'sd1, 64'hAAAA_AAAA_AAAA_AAAA);
		repeat (6) send(CMD_POP, 3'($urandom_range(0, 7)), '0, '0);
		send(CMD_POP, 3'd0, '0, '0);

		// Random traffic under several masks.
		run_phase(8'hFF, 60, 30, 1'b0, 10);
		run_phase(8'($urandom_range(1, 254)), 50, 30, 1'b0, 25);

		// Fill sensor 0 past its depth, then disable it while still full.
		run_phase(8'h01, 95, 80, 1'b0, 10);
		drain();
		write_enable_mask(8'h00);
		send(CMD_PUSH, 3'd0, random_stamp(), random_payload());
		run_phase(8'h00, 30, 20, 1'b0, 10);

		run_phase(8'h80, 90, 20, 1'b0, 0);

		// Round-robin pushes fill every queue to the brim, then pops alone drain them with every sensor disabled.
		run_phase(8'hFF, 100, 520, 1'b1, 10);
		run_phase(8'h00, 0, 520, 1'b0, 25);

		// Closing stretch at full rate on both sides.
		run_phase(8'($urandom_range(0, 255)), 55, 40, 1'b0, 0);

		drain();
		repeat (30) @(posedge clk);
		if (sb.pending() != 0)
			sb.mismatch($sformatf("%0d results never arrived", sb.pending()));

		$display("covered %0d stored entries, %0d merged out, peak occupancy %0d of %0d",
			sb.stored, sb.merged, sb.peak, NUM_SENSORS * QUEUE_DEPTH);
		$display("refusals: %0d disabled sensor, %0d full queue, %0d empty pop",
			sb.refused[CAUSE_NOT_ENABLED], sb.refused[CAUSE_QUEUE_FULL],
			sb.refused[CAUSE_EMPTY]);
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* timestamp_ordered_sensor_merge_core.f */
+incdir+rtl
rtl/tsm_pkg.sv
rtl/timestamp_ordered_sensor_merge_core.sv
verif/tb_timestamp_ordered_sensor_merge_core.sv
